/* rtl/esc_pkg.sv */
package esc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_LOWEST   = 2'd0;
  localparam logic [1:0] CFG_HIGHEST  = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  localparam logic [3:0] RST_LOWEST   = 4'd0;
  localparam logic [3:0] RST_HIGHEST  = 4'd15;
  localparam logic [3:0] RST_CAPACITY = 4'd4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic enq;
    logic dir_up;
    logic dir_dn;
    logic step_begin;
    logic unload;
    logic meta_latch;
    logic pop;
    logic al_inc;
    logic meta_wb;
    logic step_move;
    logic flip;
    logic result;
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_range;
    logic scan_last;
    logic above;
    logic below;
    logic budget_zero;
    logic can_board;
    logic board_ok;
    logic go_on;
    logic rev;
    logic out_free;
  } sts_t;

endpackage

/* rtl/esc_ram.sv */
module esc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/esc_dp.sv */
module esc_dp #(
  parameter int FLOORS      = 16,
  parameter int NUM_CARS    = 2,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [esc_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic [esc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [3:0]                           cfg_data,
  input  esc_pkg::cmd_t                        cmd,
  output esc_pkg::sts_t                        sts
);

  localparam int FLW    = $clog2(FLOORS);
  localparam int VW     = (FLW > 4) ? FLW : 4;
  localparam int CW     = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int SLOTS  = NUM_CARS * FLOORS;
  localparam int AW     = $clog2(SLOTS);
  localparam int MDEPTH = 2 * SLOTS;
  localparam int MAW    = $clog2(MDEPTH);
  localparam int DDEPTH = 2 * SLOTS * QUEUE_DEPTH;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int BUDGET = 4 * FLOORS * (2 * FLOORS * QUEUE_DEPTH + 16);
  localparam int BW     = $clog2(BUDGET + 1);

  // configuration
  logic [3:0] lo_cfg_r, hi_cfg_r, cap_r;
  // current call
  logic [3:0] floor_r, dest_r;
  logic       down_r, known_r;
  // dispatch scan
  logic [CW-1:0] idx_r, car_r;
  logic [VW:0]   best_d_r;
  // per-car state
  logic [FLW-1:0] car_floor_r [NUM_CARS];
  logic [3:0]     riders_r    [NUM_CARS];
  // non-empty flags, one per slot
  logic [SLOTS-1:0] up_nz_r, dn_nz_r, al_nz_r;
  // run state
  logic           dir_dn_r, dropped_r, m_nz_r, al_hit_r;
  logic [7:0]     delivered_r;
  logic [BW-1:0]  budget_r;
  logic [QCW-1:0] cnt_r;
  logic [HW-1:0]  head_r;
  logic [FLW-1:0] ad_r;
  logic           out_valid_r;
  logic [esc_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [VW-1:0]  lo_v, hi_v, floor_v, cur_fv, dest_v, scan_fv, car_gap;
  logic [FLW-1:0] cur_f;
  logic [3:0]     riders_c;
  logic [AW-1:0]  slot_f, slot_call, slot_d;
  logic [FLOORS-1:0] up_c, dn_c, al_c, mask_ge;
  logic [MAW-1:0] m_raddr, m_waddr;
  logic           m_we;
  logic [HW+QCW-1:0] m_wdata, m_q;
  logic [QCW-1:0] m_cnt;
  logic [HW-1:0]  m_head;
  logic [QCW:0]   pos_sum;
  logic [HW-1:0]  pos, head_inc;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic           d_we;
  logic [4:0]     d_q;
  logic [AW-1:0]  a_raddr, a_waddr;
  logic           a_we;
  logic [3:0]     a_wdata, a_q, a_n;
  logic [8:0]     dsum;
  logic           any_left, m_nz_sel;

  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // served range and working slot
  always_comb begin
    lo_v      = VW'(lo_cfg_r);
    hi_v      = (VW'(hi_cfg_r) > VW'(FLOORS - 1)) ? VW'(FLOORS - 1) : VW'(hi_cfg_r);
    floor_v   = VW'(floor_r);
    dest_v    = VW'(d_q[3:0]);
    cur_f     = car_floor_r[car_r];
    cur_fv    = VW'(cur_f);
    riders_c  = riders_r[car_r];
    slot_f    = AW'(car_r * FLOORS + cur_f);
    slot_call = AW'(car_r * FLOORS + floor_v);
    slot_d    = AW'(car_r * FLOORS + dest_v);
    up_c      = up_nz_r[car_r * FLOORS +: FLOORS];
    dn_c      = dn_nz_r[car_r * FLOORS +: FLOORS];
    al_c      = al_nz_r[car_r * FLOORS +: FLOORS];
    for (int fl = 0; fl < FLOORS; fl++) begin
      mask_ge[fl] = (FLW + 1)'(fl) >= {1'b0, cur_f};
    end
    scan_fv = VW'(car_floor_r[idx_r]);
    car_gap = (scan_fv > floor_v) ? scan_fv - floor_v : floor_v - scan_fv;
    any_left = |(up_c | dn_c | al_c);
  end

  // status to the sequencer
  always_comb begin
    sts.in_range    = !(floor_v < lo_v || floor_v > hi_v);
    sts.scan_last   = idx_r == CW'(NUM_CARS - 1);
    sts.above       = |((al_c | up_c) & mask_ge);
    sts.below       = |((al_c | dn_c) & ~mask_ge);
    sts.budget_zero = budget_r == '0;
    sts.can_board   = (cnt_r != '0) && (riders_c < cap_r);
    sts.board_ok    = d_q[4] && !(dest_v < lo_v || dest_v > hi_v);
    sts.go_on       = dir_dn_r ? (sts.below && cur_fv > lo_v)
                               : (sts.above && cur_fv < hi_v);
    sts.rev         = dir_dn_r ? sts.above : sts.below;
    sts.out_free    = !out_valid_r || out_tready;
  end

  // queue bookkeeping RAM: head and count per direction and slot
  always_comb begin
    if (cmd.unload) begin
      m_raddr  = MAW'(dir_dn_r * SLOTS + slot_f);
      m_nz_sel = dir_dn_r ? dn_nz_r[slot_f] : up_nz_r[slot_f];
    end else begin
      m_raddr  = MAW'(down_r * SLOTS + slot_call);
      m_nz_sel = down_r ? dn_nz_r[slot_call] : up_nz_r[slot_call];
    end
    m_cnt   = m_nz_r ? m_q[QCW-1:0] : '0;
    m_head  = m_nz_r ? m_q[HW+QCW-1:QCW] : '0;
    pos_sum = (QCW + 1)'(m_head) + (QCW + 1)'(m_cnt);
    pos     = (pos_sum >= (QCW + 1)'(QUEUE_DEPTH)) ?
              HW'(pos_sum - (QCW + 1)'(QUEUE_DEPTH)) : HW'(pos_sum);
    head_inc = ((HW + 1)'(head_r) + 1'b1 >= (HW + 1)'(QUEUE_DEPTH)) ?
               '0 : HW'((HW + 1)'(head_r) + 1'b1);
    m_we    = (cmd.enq && m_cnt < QCW'(QUEUE_DEPTH)) || cmd.meta_wb;
    if (cmd.meta_wb) begin
      m_waddr = MAW'(dir_dn_r * SLOTS + slot_f);
      m_wdata = {head_r, cnt_r};
    end else begin
      m_waddr = MAW'(down_r * SLOTS + slot_call);
      m_wdata = {m_head, QCW'(m_cnt + 1'b1)};
    end
  end

  // waiting destination RAM
  always_comb begin
    d_we    = cmd.enq && m_cnt < QCW'(QUEUE_DEPTH);
    d_waddr = DAW'((down_r * SLOTS + slot_call) * QUEUE_DEPTH + pos);
    d_raddr = DAW'((dir_dn_r * SLOTS + slot_f) * QUEUE_DEPTH + head_r);
  end

  // alighting count RAM
  always_comb begin
    a_raddr = cmd.pop ? slot_d : slot_f;
    a_n     = al_hit_r ? a_q : 4'd0;
    a_we    = cmd.al_inc;
    a_waddr = AW'(car_r * FLOORS + ad_r);
    a_wdata = a_n + 4'd1;
    dsum    = {1'b0, delivered_r} + 9'(a_n);
  end

  esc_ram #(.WIDTH(HW + QCW), .DEPTH(MDEPTH)) u_meta (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_q)
  );

  esc_ram #(.WIDTH(5), .DEPTH(DDEPTH)) u_dest (
    .clk(clk), .we(d_we), .waddr(d_waddr),
    .wdata({known_r, dest_r & {4{known_r}}}),
    .raddr(d_raddr), .rdata(d_q)
  );

  esc_ram #(.WIDTH(4), .DEPTH(SLOTS)) u_alight (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_q)
  );

  // control state: configuration, flags, per-car state, output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_cfg_r    <= esc_pkg::RST_LOWEST;
      hi_cfg_r    <= esc_pkg::RST_HIGHEST;
      cap_r       <= esc_pkg::RST_CAPACITY;
      up_nz_r     <= '0;
      dn_nz_r     <= '0;
      al_nz_r     <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CARS; c++) begin
        car_floor_r[c] <= '0;
        riders_r[c]    <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          esc_pkg::CFG_LOWEST:   lo_cfg_r <= cfg_data;
          esc_pkg::CFG_HIGHEST:  hi_cfg_r <= cfg_data;
          esc_pkg::CFG_CAPACITY: cap_r    <= cfg_data;
          default: ;
        endcase
      end
      // join the call to its queue
      if (cmd.enq && m_cnt < QCW'(QUEUE_DEPTH)) begin
        if (down_r) dn_nz_r[slot_call] <= 1'b1;
        else        up_nz_r[slot_call] <= 1'b1;
      end
      // unload riders bound here
      if (cmd.unload) begin
        al_nz_r[slot_f] <= 1'b0;
        riders_r[car_r] <= (riders_c > a_n) ? riders_c - a_n : 4'd0;
      end
      if (cmd.pop && sts.board_ok) begin
        riders_r[car_r] <= riders_c + 4'd1;
      end
      if (cmd.al_inc) begin
        al_nz_r[a_waddr] <= 1'b1;
      end
      if (cmd.meta_wb) begin
        if (dir_dn_r) dn_nz_r[slot_f] <= cnt_r != '0;
        else          up_nz_r[slot_f] <= cnt_r != '0;
      end
      if (cmd.step_move) begin
        car_floor_r[car_r] <= dir_dn_r ? cur_f - 1'b1 : cur_f + 1'b1;
      end
      // hold the result until taken
      if (cmd.result) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and run registers
  always_ff @(posedge clk) begin
    m_nz_r   <= m_nz_sel;
    al_hit_r <= al_nz_r[a_raddr];
    if (cmd.load) begin
      floor_r   <= in_tdata[3:0];
      down_r    <= in_tdata[4];
      dest_r    <= in_tdata[8:5];
      known_r   <= in_tdata[9];
      idx_r     <= '0;
      car_r     <= '0;
      best_d_r  <= '1;
      dropped_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      if ({1'b0, car_gap} < best_d_r) begin
        best_d_r <= {1'b0, car_gap};
        car_r    <= idx_r;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.enq) begin
      delivered_r <= '0;
      budget_r    <= BW'(BUDGET);
      if (m_cnt >= QCW'(QUEUE_DEPTH)) dropped_r <= 1'b1;
    end
    if (cmd.dir_up) dir_dn_r <= 1'b0;
    if (cmd.dir_dn) dir_dn_r <= 1'b1;
    if (cmd.flip)   dir_dn_r <= ~dir_dn_r;
    if (cmd.step_begin) budget_r <= budget_r - 1'b1;
    if (cmd.unload) delivered_r <= dsum[8] ? 8'hff : dsum[7:0];
    if (cmd.meta_latch) begin
      cnt_r  <= m_cnt;
      head_r <= m_head;
    end
    if (cmd.pop) begin
      cnt_r  <= cnt_r - 1'b1;
      head_r <= head_inc;
      ad_r   <= FLW'(dest_v);
    end
    if (cmd.result) begin
      if (sts.in_range) begin
        out_data_r <= {6'd0, any_left, dropped_r, delivered_r, cur_fv[3:0],
                       3'(car_r), 1'b1};
      end else begin
        out_data_r <= '0;
      end
    end
  end

endmodule

/* rtl/esc_ctrl.sv */
module esc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  esc_pkg::sts_t sts,
  output esc_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_QRD    = 4'd3;
  localparam logic [3:0] S_ENQ    = 4'd4;
  localparam logic [3:0] S_DIR    = 4'd5;
  localparam logic [3:0] S_STEP   = 4'd6;
  localparam logic [3:0] S_UNLOAD = 4'd7;
  localparam logic [3:0] S_BLATCH = 4'd8;
  localparam logic [3:0] S_BRD    = 4'd9;
  localparam logic [3:0] S_BDEST  = 4'd10;
  localparam logic [3:0] S_BALI   = 4'd11;
  localparam logic [3:0] S_MOVE   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_tready = state_r == S_IDLE;

  // sequence one call through dispatch and its run
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK:  state_nxt = sts.in_range ? S_SCAN : S_DONE;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_QRD;
      end
      S_QRD:    state_nxt = S_ENQ;
      S_ENQ: begin
        cmd.enq   = 1'b1;
        state_nxt = S_DIR;
      end
      S_DIR: begin
        if (sts.above) begin
          cmd.dir_up = 1'b1;
          state_nxt  = S_STEP;
        end else if (sts.below) begin
          cmd.dir_dn = 1'b1;
          state_nxt  = S_STEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_STEP: begin
        if (sts.budget_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step_begin = 1'b1;
          state_nxt      = S_UNLOAD;
        end
      end
      S_UNLOAD: begin
        cmd.unload = 1'b1;
        state_nxt  = S_BLATCH;
      end
      S_BLATCH: begin
        cmd.meta_latch = 1'b1;
        state_nxt      = S_BRD;
      end
      S_BRD: begin
        if (sts.can_board) begin
          state_nxt = S_BDEST;
        end else begin
          cmd.meta_wb = 1'b1;
          state_nxt   = S_MOVE;
        end
      end
      S_BDEST: begin
        cmd.pop   = 1'b1;
        state_nxt = sts.board_ok ? S_BALI : S_BRD;
      end
      S_BALI: begin
        cmd.al_inc = 1'b1;
        state_nxt  = S_BRD;
      end
      S_MOVE: begin
        if (sts.go_on) begin
          cmd.step_move = 1'b1;
          state_nxt     = S_STEP;
        end else if (sts.rev) begin
          cmd.flip  = 1'b1;
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/elevator_group_scan_controller.sv */
// An out-of-range call goes straight to an all-zero result; otherwise the nearest
// car is picked, the call joins its floor queue and the car runs service steps
// (unload, board from the queue, move on or reverse) until no work is left or its
// step budget is spent. Calls are taken one at a time, a new one only in idle once
// the last result is in the output register; all cars share the queue RAMs.
// Reset (synchronous, rst_n low): configuration to defaults, all cars at floor 0,
// all queues and rider counts empty; no clearing pass is needed.
module elevator_group_scan_controller #(
  parameter int FLOORS      = 16,
  parameter int NUM_CARS    = 2,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // call_floor[3:0], call_down[4], target_floor[8:5], dest_known[9], zeros above
  input  logic [esc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // car_found[0], car_index[3:1], final_floor[7:4], delivered[15:8],
  // call_dropped[16], calls_left[17], zeros above
  output logic [esc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [3:0]                      cfg_data
);

  esc_pkg::cmd_t cmd;
  esc_pkg::sts_t sts;

  esc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  esc_dp #(
    .FLOORS(FLOORS), .NUM_CARS(NUM_CARS), .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts)
  );

endmodule

/* sim/elevator_group_scan_controller_tb.sv */
`timescale 1ns / 1ps

module elevator_group_scan_controller_tb;

  localparam int NCARS  = 2;
  localparam int NFL    = 16;
  localparam int QDEPTH = 4;
  localparam int RUN_STEPS = 4 * NFL * (2 * NFL * QDEPTH + 16);
  localparam longint CYCLE_LIMIT = longint'(4 * 1600) * longint'(RUN_STEPS * 20 + 100);

  typedef struct packed {
    logic       found;
    logic [2:0] car;
    logic [3:0] stop_floor;
    logic [7:0] delivered;
    logic       dropped;
    logic       left;
  } dispatch_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [esc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [esc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [1:0]                      cfg_index = esc_pkg::CFG_LOWEST;
  logic [3:0]                      cfg_data = '0;

  elevator_group_scan_controller dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the group state
  logic [3:0] lo_floor, hi_floor, capacity;
  int car_at [NCARS];
  int aboard [NCARS];
  logic [6:0] up_q [NCARS][NFL][QDEPTH];
  logic [6:0] dn_q [NCARS][NFL][QDEPTH];
  int up_n [NCARS][NFL];
  int dn_n [NCARS][NFL];
  int alight [NCARS][NFL];

  dispatch_t pending_dispatch [$];
  int  errors = 0;
  int  calls_sent = 0;
  int  calls_served = 0;
  int  calls_assigned = 0;
  int  calls_lost = 0;
  bit  calm = 1'b0;
  longint cycles = 0;

  function automatic bit work_up(int c, int f);
    for (int fl = f; fl < NFL; fl++)
      if (alight[c][fl] != 0 || up_n[c][fl] != 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit work_down(int c, int f);
    for (int fl = 0; fl < f && fl < NFL; fl++)
      if (alight[c][fl] != 0 || dn_n[c][fl] != 0) return 1'b1;
    return 1'b0;
  endfunction

  // board from one queue at the car's floor up to capacity
  function automatic void board_car(int c, bit down);
    int f;
    logic [6:0] e;
    f = car_at[c];
    while ((down ? dn_n[c][f] : up_n[c][f]) > 0 && aboard[c] < capacity) begin
      if (down) begin
        e = dn_q[c][f][0];
        for (int k = 0; k < QDEPTH - 1; k++) dn_q[c][f][k] = dn_q[c][f][k+1];
        dn_n[c][f]--;
      end else begin
        e = up_q[c][f][0];
        for (int k = 0; k < QDEPTH - 1; k++) up_q[c][f][k] = up_q[c][f][k+1];
        up_n[c][f]--;
      end
      if (e[6] && e[3:0] >= lo_floor && e[3:0] <= hi_floor) begin
        aboard[c]++;
        alight[c][e[3:0]]++;
      end
    end
  endfunction

  function automatic dispatch_t dispatch_call(logic [3:0] flr, bit down,
                                              logic [3:0] dest, bit known);
    dispatch_t r;
    int best, bestd, d, dir, f, budget, total;
    bit any;
    r = '0;
    if (flr < lo_floor || flr > hi_floor) return r;
    best = 0;
    bestd = 1 << 30;
    for (int c = 0; c < NCARS; c++) begin
      d = car_at[c] > flr ? car_at[c] - flr : flr - car_at[c];
      if (d < bestd) begin
        bestd = d;
        best = c;
      end
    end
    // join the floor queue
    if (down ? dn_n[best][flr] < QDEPTH : up_n[best][flr] < QDEPTH) begin
      if (down) begin
        dn_q[best][flr][dn_n[best][flr]] = known ? {3'b100, dest} : 7'd0;
        dn_n[best][flr]++;
      end else begin
        up_q[best][flr][up_n[best][flr]] = known ? {3'b100, dest} : 7'd0;
        up_n[best][flr]++;
      end
    end else begin
      r.dropped = 1'b1;
    end
    // scan until no work is left or the step budget is spent (dir 1 up, 2 down)
    dir = work_up(best, car_at[best]) ? 1 : work_down(best, car_at[best]) ? 2 : 0;
    budget = RUN_STEPS;
    total = 0;
    while (dir != 0 && budget > 0) begin
      budget--;
      f = car_at[best];
      total += alight[best][f];
      aboard[best] = aboard[best] > alight[best][f] ? aboard[best] - alight[best][f] : 0;
      alight[best][f] = 0;
      board_car(best, dir == 2);
      if (dir == 1) begin
        if (work_up(best, f) && f < hi_floor) begin
          car_at[best]++;
          continue;
        end
        dir = work_down(best, f) ? 2 : 0;
      end else begin
        if (work_down(best, f) && f > lo_floor) begin
          car_at[best]--;
          continue;
        end
        dir = work_up(best, f) ? 1 : 0;
      end
    end
    any = 1'b0;
    for (int fl = 0; fl < NFL; fl++)
      if (up_n[best][fl] != 0 || dn_n[best][fl] != 0 || alight[best][fl] != 0) any = 1'b1;
    r.found = 1'b1;
    r.car = best[2:0];
    r.stop_floor = car_at[best][3:0];
    r.delivered = total > 255 ? 8'd255 : total[7:0];
    r.left = any;
    return r;
  endfunction

  task automatic idle_gap();
    int gap, pick;
    pick = $urandom_range(99);
    gap = (calm || pick < 60) ? 0 : (pick < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send one call and record its expected dispatch on acceptance
  task automatic send_call(logic [3:0] flr, bit down, logic [3:0] dest, bit known);
    bit rdy;
    idle_gap();
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, known, dest, down, flr};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    pending_dispatch = {pending_dispatch, dispatch_call(flr, down, dest, known)};
    calls_sent++;
  endtask

  task automatic finish_sending();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    finish_sending();
    while (pending_dispatch.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_valid after its last write
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    case (idx)
      esc_pkg::CFG_LOWEST:   lo_floor = val;
      esc_pkg::CFG_HIGHEST:  hi_floor = val;
      esc_pkg::CFG_CAPACITY: capacity = val;
      default: ;
    endcase
  endtask

  task automatic set_group(logic [3:0] lo, logic [3:0] hi, logic [3:0] cap);
    wait_idle();
    write_reg(esc_pkg::CFG_LOWEST, lo);
    write_reg(esc_pkg::CFG_HIGHEST, hi);
    write_reg(esc_pkg::CFG_CAPACITY, cap);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_call();
    logic [3:0] flr;
    flr = ($urandom_range(9) != 0 && lo_floor <= hi_floor) ?
          4'($urandom_range(hi_floor, lo_floor)) : 4'($urandom_range(15));
    send_call(flr, $urandom_range(1), 4'($urandom_range(15)), $urandom_range(9) != 0);
  endtask

  // result checker: sample at the falling edge, compare on the rising edge
  bit seen_result;
  logic [esc_pkg::OUT_TDATA_W-1:0] seen_word;
  int stall_left = 0;

  always @(negedge clk) begin
    seen_result = out_tvalid && out_tready;
    seen_word = out_tdata;
  end

  always @(posedge clk) begin
    dispatch_t want, got;
    int pick;
    if (rst_n && seen_result) begin
      got = '{found: seen_word[0], car: seen_word[3:1], stop_floor: seen_word[7:4],
              delivered: seen_word[15:8], dropped: seen_word[16], left: seen_word[17]};
      if (pending_dispatch.size() == 0) begin
        $error("dispatch result with nothing outstanding: %h", seen_word);
        errors++;
      end else begin
        want = pending_dispatch.pop_front();
        calls_served++;
        if (got.found) calls_assigned++;
        if (got.dropped) calls_lost++;
        if (got.found !== want.found) begin
          $error("car_found: expected %0d, got %0d", want.found, got.found); errors++;
        end
        if (got.car !== want.car) begin
          $error("car_index: expected %0d, got %0d", want.car, got.car); errors++;
        end
        if (got.stop_floor !== want.stop_floor) begin
          $error("final_floor: expected %0d, got %0d", want.stop_floor, got.stop_floor);
          errors++;
        end
        if (got.delivered !== want.delivered) begin
          $error("delivered: expected %0d, got %0d", want.delivered, got.delivered); errors++;
        end
        if (got.dropped !== want.dropped) begin
          $error("call_dropped: expected %0d, got %0d", want.dropped, got.dropped); errors++;
        end
        if (got.left !== want.left) begin
          $error("calls_left: expected %0d, got %0d", want.left, got.left); errors++;
        end
        if (seen_word[23:18] !== '0) begin
          $error("out_tdata pad: expected 0, got %h", seen_word[23:18]); errors++;
        end
      end
    end
    // back-pressure: mostly short stalls, a few long ones
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      pick = $urandom_range(99);
      if (!calm && pick < 25) stall_left = (pick < 22) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("elevator_group_scan_controller verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    set_group(4'd0, 4'd15, 4'd4);
    // extremes of floor, direction and destination; tie goes to car 0
    send_call(4'd0, 1'b0, 4'd15, 1'b1);
    send_call(4'd15, 1'b1, 4'd0, 1'b1);
    send_call(4'd7, 1'b0, 4'd9, 1'b0);
    send_call(4'd8, 1'b1, 4'd8, 1'b1);
    send_call(4'd15, 1'b0, 4'd15, 1'b1);
    send_call(4'd0, 1'b1, 4'd0, 1'b1);
    // out-of-range calls and destinations
    set_group(4'd3, 4'd12, 4'd1);
    send_call(4'd2, 1'b0, 4'd5, 1'b1);
    send_call(4'd13, 1'b1, 4'd5, 1'b1);
    send_call(4'd5, 1'b0, 4'd14, 1'b1);
    send_call(4'd12, 1'b1, 4'd1, 1'b1);
    send_call(4'd3, 1'b0, 4'd12, 1'b1);
    // fill one floor queue past its depth with unserved callers
    for (int k = 0; k < 6; k++) send_call(4'd6, 1'b1, 4'd6, k[0]);
    // empty range rejects every call as out of range
    set_group(4'd9, 4'd4, 4'd15);
    send_call(4'd9, 1'b0, 4'd10, 1'b1);
    send_call(4'd4, 1'b1, 4'd3, 1'b1);
    // cars left outside a narrow range
    set_group(4'd0, 4'd2, 4'd2);
    send_call(4'd1, 1'b0, 4'd2, 1'b1);
    send_call(4'd2, 1'b1, 4'd0, 1'b1);
    set_group(4'd15, 4'd15, 4'd15);
    send_call(4'd15, 1'b0, 4'd15, 1'b1);
    send_call(4'd15, 1'b1, 4'd14, 1'b1);
  endtask

  task automatic test_sweep();
    logic [3:0] lo, hi;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_group(4'd0, 4'd15, 4'd15);
        1: set_group(4'd0, 4'd15, 4'd1);
        2: set_group(4'd10, 4'd3, 4'd4);
        3: set_group(4'd0, 4'd0, 4'd1);
        default: begin
          lo = 4'($urandom_range(15));
          hi = 4'($urandom_range(15, lo));
          set_group(lo, hi, 4'($urandom_range(15, 1)));
        end
      endcase
      calm = (ph == 5);
      repeat (ph == 2 ? 40 : 120) random_call();
      calm = 1'b0;
    end
  endtask

  task automatic test_random();
    set_group(4'd0, 4'd15, 4'd4);
    repeat (200) random_call();
    // hold new calls until every dispatch is back
    wait_idle();
    repeat (200) random_call();
  endtask

  initial begin
    lo_floor = esc_pkg::RST_LOWEST;
    hi_floor = esc_pkg::RST_HIGHEST;
    capacity = esc_pkg::RST_CAPACITY;
    foreach (car_at[c]) begin
      car_at[c] = 0;
      aboard[c] = 0;
    end
    foreach (up_n[c, f]) begin
      up_n[c][f] = 0;
      dn_n[c][f] = 0;
      alight[c][f] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset defaults in force before any register write
    repeat (10) random_call();
    test_directed();
    test_sweep();
    test_random();
    wait_idle();
    $display("Ran %0d hall calls over several floor ranges and capacities;", calls_sent);
    $display("%0d dispatched to a car, %0d lost to full queues, %0d checked.",
             calls_assigned, calls_lost, calls_served);
    if (errors == 0 && pending_dispatch.size() == 0) begin
      $display("elevator_group_scan_controller verification clean");
    end else begin
      $display("elevator_group_scan_controller verification failed");
    end
    $finish;
  end

endmodule
